### sv/eatr_pkg.sv
// Shared types and constants for the Euler-angle rotation matrix unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package eatr_pkg;

  // Request and result payloads.
  typedef struct packed {
    logic [15:0] yaw_angle;
    logic [15:0] pitch_angle;
    logic [15:0] roll_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m_r0c0;
    logic signed [15:0] m_r0c1;
    logic signed [15:0] m_r0c2;
    logic signed [15:0] m_r1c0;
    logic signed [15:0] m_r1c1;
    logic signed [15:0] m_r1c2;
    logic signed [15:0] m_r2c0;
    logic signed [15:0] m_r2c1;
    logic signed [15:0] m_r2c2;
  } out_t;

  // Unsigned Q30 working format of the series.
  localparam int          WORK_BITS = 30;
  localparam logic [30:0] WORK_ONE  = 31'h4000_0000;

  // 2*pi in Q40, split into high and low parts for two narrow multipliers.
  localparam logic [63:0] TWO_PI_Q40 = 64'h0000_0648_7ED5_110B;
  localparam int          TP_SPLIT   = 22;
  localparam logic [20:0] TP_HI      = 21'(TWO_PI_Q40 >> TP_SPLIT);
  localparam logic [21:0] TP_LO      = TWO_PI_Q40[21:0];

  // Horner divisors, innermost (highest-order) term first.
  localparam int SIN_N = 5;
  localparam int COS_N = 6;
  localparam int SIN_DIV [SIN_N] = '{110, 72, 42, 20, 6};
  localparam int COS_DIV [COS_N] = '{132, 90, 56, 30, 12, 2};

  // Pipeline depths.
  localparam int CELL_STAGES = 3;
  localparam int FRONT_STAGES = 4;
  localparam int SIN_PAD = CELL_STAGES * (COS_N - SIN_N);
  localparam int SC_LAT = FRONT_STAGES + CELL_STAGES * COS_N + 1;
  localparam int MAT_LAT = 4;

  // Data handed from one Horner cell to the next.
  typedef struct packed {
    logic [29:0] u;
    logic [30:0] acc;
  } hcell_t;

endpackage
`default_nettype wire

### sv/eatr_horner_cell.sv
// One Horner step acc = 1 - floor(floor(u*acc)/K) in Q30, three stages.
// Depends on eatr_pkg.
`default_nettype none
module eatr_horner_cell #(
  parameter int K      = 2,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                en,
  input  eatr_pkg::hcell_t    in_cell,
  input  logic [SIDE_W-1:0]   in_side,
  output eatr_pkg::hcell_t    out_cell,
  output logic [SIDE_W-1:0]   out_side
);
  import eatr_pkg::*;

  // floor(2^32/K) undershoots by at most one; fix with one compare.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);

  logic [59:0]       prod_a_r;
  logic [29:0]       u_a_r;
  logic [SIDE_W-1:0] side_a_r;
  logic [61:0]       qm_b_r;
  logic [29:0]       x_b_r;
  logic [29:0]       u_b_r;
  logic [SIDE_W-1:0] side_b_r;
  hcell_t            cell_c_r;
  logic [SIDE_W-1:0] side_c_r;

  logic [60:0] prod_a;
  logic [61:0] prod_b;
  logic [29:0] q0;
  logic [32:0] kq;
  logic [32:0] rem;
  logic [29:0] quo;
  hcell_t      cell_nxt;

  always_comb begin
    prod_a = 61'(in_cell.u) * 61'(in_cell.acc);
    prod_b = 62'(prod_a_r[59:30]) * 62'(RECIP);
    q0 = qm_b_r[61:32];
    kq = 33'(q0) * 33'(K);
    rem = {3'b000, x_b_r} - kq;
    quo = (rem >= 33'(K)) ? q0 + 30'd1 : q0;
    cell_nxt.u = u_b_r;
    cell_nxt.acc = WORK_ONE - {1'b0, quo};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= prod_a[59:0];
      u_a_r    <= in_cell.u;
      side_a_r <= in_side;
      qm_b_r   <= prod_b;
      x_b_r    <= prod_a_r[59:30];
      u_b_r    <= u_a_r;
      side_b_r <= side_a_r;
      cell_c_r <= cell_nxt;
      side_c_r <= side_b_r;
    end
  end

  assign out_cell = cell_c_r;
  assign out_side = side_c_r;

endmodule
`default_nettype wire

### sv/eatr_sincos.sv
// Sine and cosine of one binary angle: quadrant fold, angle scaling,
// a chain of Horner cells per series, rounding and quadrant signs.
// Depends on eatr_pkg and eatr_horner_cell.
`default_nettype none
module eatr_sincos #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [15:0]                 angle,
  output logic signed [FRAC_BITS+1:0] sin_val,
  output logic signed [FRAC_BITS+1:0] cos_val
);
  import eatr_pkg::*;

  localparam int AB    = ANGLE_BITS;
  localparam int W     = FRAC_BITS + 2;
  localparam int SUM_W = AB + 41;
  localparam int SH    = WORK_BITS - FRAC_BITS;
  localparam logic [31:0]   RB   = (32'd1 << SH) >> 1;
  localparam logic [AB-2:0] HALF = (AB-1)'(1) << (AB - 3);
  localparam logic [AB-2:0] QTR  = (AB-1)'(1) << (AB - 2);

  // Front stages.
  logic [AB-3:0]    d_r;
  logic             swap1_r, swap2_r, swap3_r, swap4_r;
  logic [1:0]       quad1_r, quad2_r, quad3_r, quad4_r;
  logic [AB+18:0]   ph_r;
  logic [AB+19:0]   pl_r;
  logic [29:0]      t3_r, t4_r;
  logic [29:0]      u4_r;

  logic [AB+15:0]   angle_ext;
  logic [AB-1:0]    ang;
  logic [AB-3:0]    resid;
  logic             swap;
  logic [AB-2:0]    fold;
  logic [SUM_W-1:0] tsum;
  logic [59:0]      tsq;

  always_comb begin
    angle_ext = {{AB{1'b0}}, angle};
    ang   = angle_ext[AB-1:0];
    resid = ang[AB-3:0];
    swap  = {1'b0, resid} > HALF;
    fold  = swap ? QTR - {1'b0, resid} : {1'b0, resid};
    tsum  = (SUM_W'(ph_r) << TP_SPLIT) + SUM_W'(pl_r) + (SUM_W'(1) << (AB + 9));
    tsq   = 60'(t3_r) * 60'(t3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r     <= fold[AB-3:0];
      swap1_r <= swap;
      quad1_r <= ang[AB-1:AB-2];
      ph_r    <= (AB+19)'(d_r) * (AB+19)'(TP_HI);
      pl_r    <= (AB+20)'(d_r) * (AB+20)'(TP_LO);
      swap2_r <= swap1_r;
      quad2_r <= quad1_r;
      t3_r    <= tsum[AB+39:AB+10];
      swap3_r <= swap2_r;
      quad3_r <= quad2_r;
      u4_r    <= tsq[59:30];
      t4_r    <= t3_r;
      swap4_r <= swap3_r;
      quad4_r <= quad3_r;
    end
  end

  // Horner chains.
  hcell_t      sin_link [SIN_N+1];
  logic [29:0] sin_side [SIN_N+1];
  hcell_t      cos_link [COS_N+1];
  logic [2:0]  cos_side [COS_N+1];

  assign sin_link[0] = '{u: u4_r, acc: WORK_ONE};
  assign sin_side[0] = t4_r;
  assign cos_link[0] = '{u: u4_r, acc: WORK_ONE};
  assign cos_side[0] = {quad4_r, swap4_r};

  for (genvar i = 0; i < SIN_N; i++) begin : g_sin
    eatr_horner_cell #(.K(SIN_DIV[i]), .SIDE_W(30)) u_cell (
      .clk      (clk),
      .en       (en),
      .in_cell  (sin_link[i]),
      .in_side  (sin_side[i]),
      .out_cell (sin_link[i+1]),
      .out_side (sin_side[i+1])
    );
  end

  for (genvar i = 0; i < COS_N; i++) begin : g_cos
    eatr_horner_cell #(.K(COS_DIV[i]), .SIDE_W(3)) u_cell (
      .clk      (clk),
      .en       (en),
      .in_cell  (cos_link[i]),
      .in_side  (cos_side[i]),
      .out_cell (cos_link[i+1]),
      .out_side (cos_side[i+1])
    );
  end

  // Final sine multiply, then pad to line up with the longer cosine chain.
  logic [60:0] sv_prod;
  logic [29:0] sv_r [SIN_PAD];

  assign sv_prod = 61'(sin_side[SIN_N]) * 61'(sin_link[SIN_N].acc);

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0] <= sv_prod[59:30];
      for (int i = 1; i < SIN_PAD; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
  end

  // Swap, round to FRAC_BITS, apply quadrant signs.
  logic [30:0]          smag, cmag;
  logic [31:0]          s_sum, c_sum;
  logic signed [W-1:0]  s_pos, c_pos;
  logic signed [W-1:0]  sin_nxt, cos_nxt;
  logic signed [W-1:0]  sin_r, cos_r;
  logic [1:0]           quad_f;
  logic                 swap_f;

  always_comb begin
    quad_f = cos_side[COS_N][2:1];
    swap_f = cos_side[COS_N][0];
    smag = swap_f ? cos_link[COS_N].acc : {1'b0, sv_r[SIN_PAD-1]};
    cmag = swap_f ? {1'b0, sv_r[SIN_PAD-1]} : cos_link[COS_N].acc;
    s_sum = 32'(smag) + RB;
    c_sum = 32'(cmag) + RB;
    s_pos = signed'({1'b0, s_sum[30:SH]});
    c_pos = signed'({1'b0, c_sum[30:SH]});
    case (quad_f)
      2'd0: begin sin_nxt = s_pos;  cos_nxt = c_pos;  end
      2'd1: begin sin_nxt = c_pos;  cos_nxt = -s_pos; end
      2'd2: begin sin_nxt = -s_pos; cos_nxt = -c_pos; end
      default: begin sin_nxt = -c_pos; cos_nxt = s_pos; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule
`default_nettype wire

### sv/eatr_matrix.sv
// Rotation matrix entries from six sines and cosines: two rounds of
// multiply and round, then sums and saturation into the result register.
// Depends on eatr_pkg.
`default_nettype none
module eatr_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+1:0] sy,
  input  logic signed [FRAC_BITS+1:0] cy,
  input  logic signed [FRAC_BITS+1:0] sp,
  input  logic signed [FRAC_BITS+1:0] cp,
  input  logic signed [FRAC_BITS+1:0] sr,
  input  logic signed [FRAC_BITS+1:0] cr,
  output eatr_pkg::out_t              mat
);
  import eatr_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int W  = F + 2;
  localparam int PW = 2 * W;
  localparam logic signed [PW-1:0] HALF_LSB = PW'(1) <<< (F - 1);
  localparam logic signed [W:0]    LIM      = (W+1)'(1) <<< F;

  localparam int P_CRCY = 0;
  localparam int P_SRCP = 1;
  localparam int P_CRSY = 2;
  localparam int P_SRCY = 3;
  localparam int P_CRCP = 4;
  localparam int P_SRSY = 5;
  localparam int P_CPSY = 6;
  localparam int P_CPCY = 7;
  localparam int P_SPSY = 8;
  localparam int P_SPCY = 9;
  localparam int N1     = 10;

  localparam int Q_SRT1 = 0;
  localparam int Q_SRT2 = 1;
  localparam int Q_CRT1 = 2;
  localparam int Q_CRT2 = 3;
  localparam int N2     = 4;

  function automatic logic signed [W-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] tmp;
    tmp = p + HALF_LSB;
    return signed'(tmp[F+W-1:F]);
  endfunction

  function automatic logic signed [W:0] sx(input logic signed [W-1:0] v);
    return signed'({v[W-1], v});
  endfunction

  function automatic logic [15:0] sat16(input logic signed [W:0] v);
    logic signed [W:0] s;
    logic [32:0]       ext;
    s = v;
    if (v > LIM) s = LIM;
    if (v < -LIM) s = -LIM;
    ext = {{(33-W){s[W-1]}}, s[W-1:0]};
    return ext[15:0];
  endfunction

  logic signed [W-1:0]  op_a [N1];
  logic signed [W-1:0]  op_b [N1];
  logic signed [PW-1:0] p1_r [N1];
  logic signed [W-1:0]  r1_r [N1];
  logic signed [W-1:0]  r1d_r [N1];
  logic signed [PW-1:0] p2_r [N2];
  logic signed [W-1:0]  sr1_r, cr1_r, sp1_r, sr2_r, cr2_r, sp2_r, sp3_r;
  logic signed [W-1:0]  q_a [N2];
  logic signed [W-1:0]  q_b [N2];
  logic signed [W-1:0]  r2 [N2];
  logic signed [W:0]    e [9];
  out_t                 mat_nxt;
  out_t                 mat_r;

  always_comb begin
    op_a[P_CRCY] = cr; op_b[P_CRCY] = cy;
    op_a[P_SRCP] = sr; op_b[P_SRCP] = cp;
    op_a[P_CRSY] = cr; op_b[P_CRSY] = sy;
    op_a[P_SRCY] = sr; op_b[P_SRCY] = cy;
    op_a[P_CRCP] = cr; op_b[P_CRCP] = cp;
    op_a[P_SRSY] = sr; op_b[P_SRSY] = sy;
    op_a[P_CPSY] = cp; op_b[P_CPSY] = sy;
    op_a[P_CPCY] = cp; op_b[P_CPCY] = cy;
    op_a[P_SPSY] = sp; op_b[P_SPSY] = sy;
    op_a[P_SPCY] = sp; op_b[P_SPCY] = cy;
    q_a[Q_SRT1] = sr2_r; q_b[Q_SRT1] = r1_r[P_SPSY];
    q_a[Q_SRT2] = sr2_r; q_b[Q_SRT2] = r1_r[P_SPCY];
    q_a[Q_CRT1] = cr2_r; q_b[Q_CRT1] = r1_r[P_SPSY];
    q_a[Q_CRT2] = cr2_r; q_b[Q_CRT2] = r1_r[P_SPCY];
  end

  always_comb begin
    for (int j = 0; j < N2; j++) begin
      r2[j] = rnd(p2_r[j]);
    end
    e[0] = sx(r1d_r[P_CRCY]) + sx(r2[Q_SRT1]);
    e[1] = -sx(r1d_r[P_SRCP]);
    e[2] = -sx(r1d_r[P_CRSY]) + sx(r2[Q_SRT2]);
    e[3] = sx(r1d_r[P_SRCY]) - sx(r2[Q_CRT1]);
    e[4] = sx(r1d_r[P_CRCP]);
    e[5] = -sx(r1d_r[P_SRSY]) - sx(r2[Q_CRT2]);
    e[6] = sx(r1d_r[P_CPSY]);
    e[7] = sx(sp3_r);
    e[8] = sx(r1d_r[P_CPCY]);
    mat_nxt.m_r0c0 = signed'(sat16(e[0]));
    mat_nxt.m_r0c1 = signed'(sat16(e[1]));
    mat_nxt.m_r0c2 = signed'(sat16(e[2]));
    mat_nxt.m_r1c0 = signed'(sat16(e[3]));
    mat_nxt.m_r1c1 = signed'(sat16(e[4]));
    mat_nxt.m_r1c2 = signed'(sat16(e[5]));
    mat_nxt.m_r2c0 = signed'(sat16(e[6]));
    mat_nxt.m_r2c1 = signed'(sat16(e[7]));
    mat_nxt.m_r2c2 = signed'(sat16(e[8]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N1; i++) begin
        p1_r[i]  <= PW'(op_a[i]) * PW'(op_b[i]);
        r1_r[i]  <= rnd(p1_r[i]);
        r1d_r[i] <= r1_r[i];
      end
      for (int j = 0; j < N2; j++) begin
        p2_r[j] <= PW'(q_a[j]) * PW'(q_b[j]);
      end
      sr1_r <= sr;
      cr1_r <= cr;
      sp1_r <= sp;
      sr2_r <= sr1_r;
      cr2_r <= cr1_r;
      sp2_r <= sp1_r;
      sp3_r <= sp2_r;
      mat_r <= mat_nxt;
    end
  end

  assign mat = mat_r;

endmodule
`default_nettype wire

### sv/euler_angles_to_rotation_matrix_unit.sv
// Euler-angle (Y-X-Z) rotation matrix unit, Rz(roll) * Rx(pitch) * Ry(yaw).
// An accepted request passes through the sine/cosine and matrix pipelines to out_valid.
// Throughput: one request per cycle while no held result stalls; the whole pipeline advances together.
// A held result stalls the pipeline, so up to 27 requests can be in flight.
// Reset (rst_n low, synchronous) empties the valid pipeline; data holds.
// Depends on eatr_pkg, eatr_sincos, eatr_matrix, eatr_horner_cell.
`default_nettype none
module euler_angles_to_rotation_matrix_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  eatr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output eatr_pkg::out_t out_data
);
  import eatr_pkg::*;

  localparam int W   = FRAC_BITS + 2;
  localparam int LAT = SC_LAT + MAT_LAT;

  // Advance every stage unless the result register holds a request that
  // the consumer has not taken yet. Bubbles move on like any other slot.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // One valid bit per pipeline slot; the last one is the result register.
  logic [LAT-1:0] v_r;
  logic [LAT-1:0] v_nxt;

  assign v_nxt = {v_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  assign out_valid = v_r[LAT-1];

  // Three sine/cosine pipelines run side by side, one per angle.
  logic signed [W-1:0] sy, cy, sp, cp, sr, cr;

  eatr_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_yaw (
    .clk     (clk),
    .en      (en),
    .angle   (in_data.yaw_angle),
    .sin_val (sy),
    .cos_val (cy)
  );

  eatr_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_pitch (
    .clk     (clk),
    .en      (en),
    .angle   (in_data.pitch_angle),
    .sin_val (sp),
    .cos_val (cp)
  );

  eatr_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_roll (
    .clk     (clk),
    .en      (en),
    .angle   (in_data.roll_angle),
    .sin_val (sr),
    .cos_val (cr)
  );

  // Matrix products, sums and saturation; ends in the result register.
  eatr_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk (clk),
    .en  (en),
    .sy  (sy),
    .cy  (cy),
    .sp  (sp),
    .cp  (cp),
    .sr  (sr),
    .cr  (cr),
    .mat (out_data)
  );

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An accepted request occupies the first pipeline slot.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted request lost at pipeline entry");

  // A stalled pipeline keeps every slot in place.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

### tb/sv/tb_euler_angles_to_rotation_matrix_unit.sv
// Testbench for the Euler-angle (Y-X-Z) rotation matrix unit: random and directed
// angle triples, bit-exact fixed-point prediction, and a check of the whole result struct.
// Depends on eatr_pkg and euler_angles_to_rotation_matrix_unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_euler_angles_to_rotation_matrix_unit;
  import eatr_pkg::*;

  localparam int N_RANDOM = 1800;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t pending_q[$];
  out_t matrix_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_req = 1'b0;     // ask the receiver for a long stall
  bit pause_send = 1'b0;   // hold the sender until all results are back
  int burst_left = 0;
  int gap_left = 0;

  euler_angles_to_rotation_matrix_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Horner series in unsigned Q30 with floor at every step.
  function automatic logic [63:0] series(logic [63:0] u, bit is_cos);
    logic [63:0] acc;
    int divs[6];
    int n;
    acc = 64'd1 << 30;
    if (is_cos) begin
      divs = '{132, 90, 56, 30, 12, 2};
      n = 6;
    end else begin
      divs = '{110, 72, 42, 20, 6, 1};
      n = 5;
    end
    for (int i = 0; i < n; i++)
      acc = (64'd1 << 30) - ((u * acc) >> 30) / divs[i];
    return acc;
  endfunction

  // Sine and cosine of a 16-bit binary angle, as Q1.14 integers.
  function automatic void angle_sin_cos(input logic [15:0] a, output longint s,
                                        output longint c);
    logic [63:0] r, d, t, u, sv, cv, tmp;
    logic [1:0] q;
    longint sm, cm;
    q = a[15:14];
    r = {50'd0, a[13:0]};
    d = (r > 64'd8192) ? 64'd16384 - r : r;
    t = (d * 64'h6487ED5110B + (64'd1 << 25)) >> 26;
    u = (t * t) >> 30;
    sv = (t * series(u, 1'b0)) >> 30;
    cv = series(u, 1'b1);
    if (r > 64'd8192) begin
      tmp = sv; sv = cv; cv = tmp;
    end
    sm = longint'((sv + 64'd32768) >> 16);
    cm = longint'((cv + 64'd32768) >> 16);
    case (q)
      2'd0: begin s = sm;  c = cm;  end
      2'd1: begin s = cm;  c = -sm; end
      2'd2: begin s = -sm; c = -cm; end
      default: begin s = -cm; c = sm; end
    endcase
  endfunction

  // Rounded Q1.14 product, floor after adding half an LSB.
  function automatic longint qmul(longint a, longint b);
    return (a * b + 8192) >>> 14;
  endfunction

  function automatic logic signed [15:0] clamp(longint v);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  function automatic out_t rotation_matrix(in_t req);
    longint sy, cy, sp, cp, sr, cr;
    out_t m;
    angle_sin_cos(req.yaw_angle, sy, cy);
    angle_sin_cos(req.pitch_angle, sp, cp);
    angle_sin_cos(req.roll_angle, sr, cr);
    m.m_r0c0 = clamp(qmul(cr, cy) + qmul(sr, qmul(sp, sy)));
    m.m_r0c1 = clamp(-qmul(sr, cp));
    m.m_r0c2 = clamp(-qmul(cr, sy) + qmul(sr, qmul(sp, cy)));
    m.m_r1c0 = clamp(qmul(sr, cy) - qmul(cr, qmul(sp, sy)));
    m.m_r1c1 = clamp(qmul(cr, cp));
    m.m_r1c2 = clamp(-qmul(sr, sy) - qmul(cr, qmul(sp, cy)));
    m.m_r2c0 = clamp(qmul(cp, sy));
    m.m_r2c1 = clamp(sp);
    m.m_r2c2 = clamp(qmul(cp, cy));
    return m;
  endfunction

  function automatic in_t rand_request();
    in_t r;
    logic [15:0] ang[3];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        // land on or next to a quadrant point or an octant point
        0: ang[k] = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
        1: ang[k] = 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
        default: ang[k] = 16'($urandom);
      endcase
    end
    r.yaw_angle = ang[0];
    r.pitch_angle = ang[1];
    r.roll_angle = ang[2];
    return r;
  endfunction

  // Fill the request queue: directed corners first, then random triples.
  initial begin
    logic [15:0] corners[12];
    in_t r;
    corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000,
                16'h2001, 16'h1FFF, 16'h6000, 16'h0001, 16'hBFFF, 16'h5555};
    for (int i = 0; i < 12; i++) begin
      r.yaw_angle = corners[i];
      r.pitch_angle = corners[(i + 4) % 12];
      r.roll_angle = corners[(i + 7) % 12];
      pending_q.push_back(r);
    end
    for (int i = 0; i < 8; i++) begin
      r.yaw_angle = corners[i];
      r.pitch_angle = corners[i];
      r.roll_angle = corners[i];
      pending_q.push_back(r);
    end
    for (int i = 0; i < N_RANDOM; i++) pending_q.push_back(rand_request());
  end

  // Reset, then orchestrate the two pressure phases.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // long receiver hold while the sender keeps offering
    wait (pending_q.size() < 1700);
    @(posedge clk);
    hold_req <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_req <= 1'b0;
    // sender pause until the pipeline drains
    wait (pending_q.size() < 900);
    @(posedge clk);
    pause_send <= 1'b1;
    wait (matrix_q.size() == 0);
    @(posedge clk);
    pause_send <= 1'b0;
  end

  // Driver: bursts and gaps; hold the payload while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        matrix_q.push_back(rotation_matrix(in_data));
        void'(pending_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        // pick the next request, or idle
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pause_send || pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_q[0];
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      if (pending_q.size() == 0 && !(in_valid && in_stall)) stim_done <= 1'b1;
    end
  end

  // The queue keeps the in-flight request at its head until acceptance pops it.

  // Receiver stall pattern: random runs, some stretches with none.
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_req) out_stall <= 1'b1;
    else case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_t exp_m;
    if (rst_n && out_valid && !out_stall) begin
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_m = matrix_q.pop_front();
        if (exp_m !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h got %h", exp_m, out_data);
        end
      end
    end
  end

  // Watchdog: count cycles in which no request and no result is accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // End of run: drain, wait out the latency, report.
  initial begin
    wait (stim_done);
    wait (matrix_q.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && matrix_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

### euler_angles_to_rotation_matrix_unit.f
sv/eatr_pkg.sv
sv/eatr_horner_cell.sv
sv/eatr_sincos.sv
sv/eatr_matrix.sv
sv/euler_angles_to_rotation_matrix_unit.sv
tb/sv/tb_euler_angles_to_rotation_matrix_unit.sv
